### rtl/mcr_pkg.sv
// Package: shared types and constants of the midpoint circle rasterizer.
package mcr_pkg;

  localparam int PIX_BITS   = 12;
  localparam int COLOR_BITS = 24;
  localparam int GROUP_PTS  = 8;
  localparam int PT_BITS    = $clog2(GROUP_PTS);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

endpackage

### rtl/mcr_front.sv
// Front end: accepts items, runs the midpoint iteration, issues group descriptors.
module mcr_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic [COORD_BITS-1:0]     center_x,
  input  logic [COORD_BITS-1:0]     center_y,
  input  logic [COORD_BITS-1:0]     radius,
  output logic                      push,
  output logic [4*COORD_BITS:0]     push_data,
  input  logic                      q_full
);

  localparam int DW = COORD_BITS + 3;

  logic                         active;
  logic [COORD_BITS-1:0]        offset_x;
  logic [COORD_BITS-1:0]        offset_y;
  logic signed [DW-1:0]         decision;
  logic [COORD_BITS-1:0]        stored_center_x;
  logic [COORD_BITS-1:0]        stored_center_y;

  logic                         active_next;
  logic [COORD_BITS-1:0]        offset_x_next;
  logic [COORD_BITS-1:0]        offset_y_next;
  logic signed [DW-1:0]         decision_next;
  logic [COORD_BITS-1:0]        cx_next;
  logic [COORD_BITS-1:0]        cy_next;

  logic                         accept;
  logic                         is_start;
  logic                         done;
  logic signed [DW-1:0]         x_ext;
  logic signed [DW-1:0]         y_ext;
  logic signed [DW-1:0]         r_ext;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_start = (operation == mcr_pkg::OP_START);

  assign x_ext = signed'({3'b000, offset_x});
  assign y_ext = signed'({3'b000, offset_y});
  assign r_ext = signed'({3'b000, radius});

  always_comb begin
    active_next   = active;
    offset_x_next = offset_x;
    offset_y_next = offset_y;
    decision_next = decision;
    cx_next       = stored_center_x;
    cy_next       = stored_center_y;
    if (is_start) begin
      cx_next       = center_x;
      cy_next       = center_y;
      offset_x_next = '0;
      offset_y_next = radius;
      decision_next = DW'(1) - r_ext;
    end else begin
      if (decision < 0) begin
        decision_next = decision + (x_ext <<< 1) + DW'(3);
      end else begin
        decision_next = decision + ((x_ext - y_ext) <<< 1) + DW'(5);
        offset_y_next = offset_y - COORD_BITS'(1);
      end
      offset_x_next = offset_x + COORD_BITS'(1);
    end
    done        = !(offset_x_next < offset_y_next);
    active_next = !done;
  end

  assign push      = accept && (is_start || active);
  assign push_data = {done, cx_next, cy_next, offset_x_next, offset_y_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      offset_x        <= '0;
      offset_y        <= '0;
      decision        <= '0;
      stored_center_x <= '0;
      stored_center_y <= '0;
    end else if (push) begin
      active          <= active_next;
      offset_x        <= offset_x_next;
      offset_y        <= offset_y_next;
      decision        <= decision_next;
      stored_center_x <= cx_next;
      stored_center_y <= cy_next;
    end
  end

endmodule

### rtl/mcr_queue.sv
// Two-entry descriptor queue between front and back ends.
module mcr_queue #(
  parameter int WIDTH = 41
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output logic [WIDTH-1:0] q_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/mcr_back.sv
// Back end: expands each descriptor into eight points on a registered output.
module mcr_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [mcr_pkg::COLOR_BITS-1:0]    cfg_data,
  input  logic                              q_valid,
  input  logic [4*COORD_BITS:0]             q_data,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mcr_pkg::PIX_BITS-1:0]      pixel_x,
  output logic [mcr_pkg::PIX_BITS-1:0]      pixel_y,
  output logic [mcr_pkg::COLOR_BITS-1:0]    pixel_value,
  output logic                              last_of_group,
  output logic                              circle_done
);

  localparam int PW  = mcr_pkg::PIX_BITS;
  localparam int EXT = (COORD_BITS + 1 > PW) ? COORD_BITS + 1 : PW;

  logic [mcr_pkg::COLOR_BITS-1:0] pixel_color;
  logic                           cur_valid;
  logic [4*COORD_BITS:0]          cur;
  logic [mcr_pkg::PT_BITS-1:0]    pt;

  logic                           advance;
  logic                           last_pt;
  logic                           cur_done;
  logic [COORD_BITS-1:0]          cx, cy, ox, oy, a, b;
  logic [EXT-1:0]                 cx_e, cy_e, a_e, b_e, px, py;

  assign {cur_done, cx, cy, ox, oy} = cur;

  assign advance = cur_valid && (!out_valid || out_ready);
  assign last_pt = (pt == mcr_pkg::PT_BITS'(mcr_pkg::GROUP_PTS - 1));
  assign pop     = q_valid && (!cur_valid || (advance && last_pt));

  // pt[2] swaps x/y roles, pt[1] negates the x term, pt[0] the y term
  assign a    = pt[2] ? oy : ox;
  assign b    = pt[2] ? ox : oy;
  assign cx_e = {{(EXT-COORD_BITS){1'b0}}, cx};
  assign cy_e = {{(EXT-COORD_BITS){1'b0}}, cy};
  assign a_e  = {{(EXT-COORD_BITS){1'b0}}, a};
  assign b_e  = {{(EXT-COORD_BITS){1'b0}}, b};
  assign px   = pt[1] ? (cx_e - a_e) : (cx_e + a_e);
  assign py   = pt[0] ? (cy_e - b_e) : (cy_e + b_e);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_color <= '0;
    end else if (cfg_valid) begin
      pixel_color <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pt        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        pt        <= '0;
      end else if (advance) begin
        if (last_pt) cur_valid <= 1'b0;
        pt <= pt + mcr_pkg::PT_BITS'(1);
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    if (advance) begin
      pixel_x       <= px[PW-1:0];
      pixel_y       <= py[PW-1:0];
      pixel_value   <= pixel_color;
      last_of_group <= last_pt;
      circle_done   <= last_pt && cur_done;
    end
  end

endmodule

### rtl/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer.
// A start beat (operation 0) latches center and radius and yields the eight
// symmetric points of offset (0, radius); each step beat (operation 1) runs
// one midpoint iteration and yields eight more, the eighth flagged
// last_of_group and, on the circle's final group, circle_done. A step with
// no circle in progress is accepted and yields nothing. Points leave one
// per cycle through a registered output while work is waiting and
// out_ready is high; the front end takes an item whenever the two-entry
// descriptor queue has room, so up to two groups may wait behind the one
// being sent. The first point passes through the queue entry, the back
// end's current descriptor and the output register. pixel_color is written
// through the cfg channel, which is always ready.
module midpoint_circle_rasterizer #(
  parameter int COORD_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mcr_pkg::COLOR_BITS-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic [COORD_BITS-1:0]             center_x,
  input  logic [COORD_BITS-1:0]             center_y,
  input  logic [COORD_BITS-1:0]             radius,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x,
  output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y,
  output logic [mcr_pkg::COLOR_BITS-1:0]    pixel_value,
  output logic                              last_of_group,
  output logic                              circle_done
);

  localparam int QW = 4 * COORD_BITS + 1;

  logic          push;
  logic [QW-1:0] push_data;
  logic          q_full;
  logic          pop;
  logic          q_valid;
  logic [QW-1:0] q_data;
  logic [mcr_pkg::PIX_BITS-1:0] px;
  logic [mcr_pkg::PIX_BITS-1:0] py;

  assign cfg_ready = 1'b1;
  assign pixel_x   = signed'(px);
  assign pixel_y   = signed'(py);

  mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  mcr_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  mcr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_x       (px),
    .pixel_y       (py),
    .pixel_value   (pixel_value),
    .last_of_group (last_of_group),
    .circle_done   (circle_done)
  );

endmodule
